[src/dppt_pkg.sv]
// ----------------------------------------------------------------------------
// dppt_pkg: shared constants for the pulse-period tachometer
// Register indexes, reset values, field widths and serial step counts.
// ----------------------------------------------------------------------------
package dppt_pkg;

  // Field widths
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned LIMIT_W    = 8;
  localparam int unsigned TIMEOUT_W  = 16;
  localparam int unsigned NUM_W      = 24;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned RAW_W      = 24;
  localparam int unsigned SCALED_W   = 37;
  localparam int unsigned PROD_W     = SCALE_W + RAW_W;

  // Period counter width default
  localparam int unsigned DEFAULT_PERIOD_BITS = 16;

  // APB register map
  localparam int unsigned REG_IDX_W  = 2;
  localparam int unsigned PADDR_W    = REG_IDX_W + 2;
  localparam int unsigned PDATA_W    = 32;
  localparam logic [REG_IDX_W-1:0] REG_SPEED_SCALE    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_LIMIT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_RATE_NUMERATOR = 2'd3;

  // Register reset values
  localparam logic [SCALE_W-1:0]   SCALE_RST     = 16'd10;
  localparam logic [LIMIT_W-1:0]   LIMIT_RST     = 8'd20;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 16'd3000;
  localparam logic [NUM_W-1:0]     NUMERATOR_RST = 24'd120000;

  // Scaled speed is in tenths
  localparam int unsigned TENTHS_W = 4;
  localparam logic [TENTHS_W:0] TENTHS_DIV = 5'd10;

  // Serial step counts
  localparam int unsigned DIV_STEPS = RAW_W;
  localparam int unsigned MUL_STEPS = SCALE_W;
  localparam int unsigned D10_STEPS = PROD_W;
  localparam int unsigned STEP_W    = $clog2(D10_STEPS);

endpackage

[src/debounced_pulse_period_tachometer.sv]
// ----------------------------------------------------------------------------
// debounced_pulse_period_tachometer: period-measuring tachometer
// Integrating debounce, tick-period counter with timeout, and bit-serial
// speed computation (divide, scale, divide by ten).
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i/in_ready_o, sensor_level_i): one transfer per
//   timer tick carrying the raw sensor pin level. Output channel
//   (out_valid_o/out_ready_i): exactly one result transfer per tick, in order.
//   APB port: speed_scale at 0x0, debounce_limit at 0x4, timeout_ticks at 0x8,
//   rate_numerator at 0xC; write only while the block is idle.
// Processing
//   A tick without a rising filtered edge passes from input transfer through
//   S_DONE to the output register. A tick with an edge and a nonzero period
//   runs the serial datapath: 24 restoring divide steps, 16 shift-add
//   multiply steps and 40 divide-by-ten steps, all in the single shared
//   40-bit shift register. One tick is in flight at a time.
// Reset
//   rst_ni clears the debounce, period and speed state and loads the register
//   reset values; no result is pending.
// Stall
//   A finished result waits in the output register; the next tick is taken
//   and processed meanwhile, then holds until the output register frees.
// ----------------------------------------------------------------------------
module debounced_pulse_period_tachometer
  import dppt_pkg::*;
#(
  parameter int unsigned PERIOD_BITS = DEFAULT_PERIOD_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // APB configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready,
  // tick input
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 sensor_level_i,
  // result output
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 filtered_level_o,
  output logic [PERIOD_W-1:0]  period_ticks_o,
  output logic [RAW_W-1:0]     speed_raw_o,
  output logic [SCALED_W-1:0]  speed_scaled_o,
  output logic                 new_measurement_o,
  output logic                 stopped_o
);

  localparam int unsigned CMP_W = (PERIOD_BITS > TIMEOUT_W) ? PERIOD_BITS : TIMEOUT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_D10  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // Configuration registers
  logic [SCALE_W-1:0]   scale_q;
  logic [LIMIT_W-1:0]   limit_q;
  logic [TIMEOUT_W-1:0] timeout_q;
  logic [NUM_W-1:0]     num_q;

  // Tick state
  logic [LIMIT_W-1:0]     dbc_q, dbc_d;
  logic                   clean_q, clean_d;
  logic                   prev_clean_q;
  logic [PERIOD_BITS-1:0] tick_q, tick_d;
  logic                   active_q, active_d;
  logic [PERIOD_W-1:0]    period_q, period_d;
  logic [RAW_W-1:0]       raw_q, raw_d;
  logic [SCALED_W-1:0]    scaled_q, scaled_d;
  logic                   fresh_q, fresh_d;

  // Serial datapath
  logic [2:0]             state_q, state_d;
  logic [STEP_W-1:0]      step_q, step_d;
  logic [PROD_W-1:0]      wk_q, wk_d;
  logic [PERIOD_BITS-1:0] rem_q, rem_d;
  logic [PERIOD_BITS-1:0] div_q, div_d;
  logic [SCALE_W-1:0]     scl_q, scl_d;
  logic [TENTHS_W-1:0]    r10_q, r10_d;

  // Output register
  logic                   out_valid_q, out_valid_d;
  logic                   out_level_q;
  logic [PERIOD_W-1:0]    out_period_q;
  logic [RAW_W-1:0]       out_raw_q;
  logic [SCALED_W-1:0]    out_scaled_q;
  logic                   out_fresh_q;
  logic                   out_stopped_q;
  logic                   out_load;

  logic                   in_xfer;
  logic                   cfg_wr;
  logic [REG_IDX_W-1:0]   cfg_idx;

  // Per-tick combinational update
  logic                   t_clean;
  logic [LIMIT_W-1:0]     t_dbc;
  logic [PERIOD_BITS-1:0] t_tick;
  logic                   t_timeout;
  logic                   t_edge;

  // Serial step terms
  logic [PERIOD_BITS:0]   div_trial;
  logic [PERIOD_BITS:0]   div_diff;
  logic                   div_ge;
  logic [TENTHS_W:0]      d10_trial;
  logic [TENTHS_W:0]      d10_diff;
  logic                   d10_ge;

  // --------------------------------------------------------------------------
  // APB register file: writes complete in the access phase, no wait states
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q   <= SCALE_RST;
      limit_q   <= LIMIT_RST;
      timeout_q <= TIMEOUT_RST;
      num_q     <= NUMERATOR_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SPEED_SCALE:    scale_q   <= pwdata[SCALE_W-1:0];
        REG_DEBOUNCE_LIMIT: limit_q   <= pwdata[LIMIT_W-1:0];
        REG_TIMEOUT_TICKS:  timeout_q <= pwdata[TIMEOUT_W-1:0];
        REG_RATE_NUMERATOR: num_q     <= pwdata[NUM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SPEED_SCALE:    prdata = PDATA_W'(scale_q);
      REG_DEBOUNCE_LIMIT: prdata = PDATA_W'(limit_q);
      REG_TIMEOUT_TICKS:  prdata = PDATA_W'(timeout_q);
      REG_RATE_NUMERATOR: prdata = PDATA_W'(num_q);
      default:            prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Tick update: debounce, count, timeout, then rising edge of clean level
  // --------------------------------------------------------------------------
  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    t_clean = clean_q;
    t_dbc   = dbc_q;
    if (!sensor_level_i) begin
      // drop the level only once the integrator has drained
      if (dbc_q == '0) t_clean = 1'b0;
      else             t_dbc   = dbc_q - 1'b1;
    end else begin
      if (dbc_q >= limit_q) t_clean = 1'b1;
      else                  t_dbc   = dbc_q + 1'b1;
    end

    // advance the period counter, saturating at full scale
    t_tick = tick_q;
    if (active_q && (tick_q != '1)) t_tick = tick_q + 1'b1;

    t_timeout = (CMP_W'(t_tick) >= CMP_W'(timeout_q));
    if (t_timeout) t_tick = '0;

    t_edge = t_clean && !prev_clean_q;
  end

  // --------------------------------------------------------------------------
  // Serial datapath steps
  // --------------------------------------------------------------------------
  // restoring divide of the numerator by the measured period, MSB first
  assign div_trial = {rem_q, wk_q[RAW_W-1]};
  assign div_ge    = (div_trial >= {1'b0, div_q});
  assign div_diff  = div_trial - {1'b0, div_q};

  // restoring divide of the product by ten, MSB first
  assign d10_trial = {r10_q, wk_q[PROD_W-1]};
  assign d10_ge    = (d10_trial >= TENTHS_DIV);
  assign d10_diff  = d10_trial - TENTHS_DIV;

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    wk_d     = wk_q;
    rem_d    = rem_q;
    div_d    = div_q;
    scl_d    = scl_q;
    r10_d    = r10_q;
    dbc_d    = dbc_q;
    clean_d  = clean_q;
    tick_d   = tick_q;
    active_d = active_q;
    period_d = period_q;
    raw_d    = raw_q;
    scaled_d = scaled_q;
    fresh_d  = fresh_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          dbc_d   = t_dbc;
          clean_d = t_clean;
          tick_d  = t_tick;
          fresh_d = t_edge;
          state_d = S_DONE;
          if (t_timeout) begin
            active_d = 1'b0;
            period_d = '0;
            raw_d    = '0;
            scaled_d = '0;
          end
          if (t_edge) begin
            active_d = 1'b1;
            period_d = PERIOD_W'(t_tick);
            tick_d   = '0;
            if (t_tick == '0) begin
              // arming edge: no period yet, report zero speed
              raw_d    = '0;
              scaled_d = '0;
            end else begin
              div_d   = t_tick;
              rem_d   = '0;
              wk_d    = PROD_W'(num_q);
              scl_d   = scale_q;
              step_d  = '0;
              state_d = S_DIV;
            end
          end
        end
      end

      S_DIV: begin
        rem_d  = div_ge ? div_diff[PERIOD_BITS-1:0] : div_trial[PERIOD_BITS-1:0];
        wk_d   = {wk_q[PROD_W-2:0], div_ge};
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          raw_d   = {wk_q[RAW_W-2:0], div_ge};
          wk_d    = '0;
          step_d  = '0;
          state_d = S_MUL;
        end
      end

      S_MUL: begin
        // shift-add, scale MSB first
        wk_d   = {wk_q[PROD_W-2:0], 1'b0} + (scl_q[SCALE_W-1] ? PROD_W'(raw_q) : '0);
        scl_d  = {scl_q[SCALE_W-2:0], 1'b0};
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(MUL_STEPS - 1)) begin
          r10_d   = '0;
          step_d  = '0;
          state_d = S_D10;
        end
      end

      S_D10: begin
        r10_d  = d10_ge ? d10_diff[TENTHS_W-1:0] : d10_trial[TENTHS_W-1:0];
        wk_d   = {wk_q[PROD_W-2:0], d10_ge};
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(D10_STEPS - 1)) begin
          scaled_d = {wk_q[SCALED_W-2:0], d10_ge};
          step_d   = '0;
          state_d  = S_DONE;
        end
      end

      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= '0;
      dbc_q        <= '0;
      clean_q      <= 1'b0;
      prev_clean_q <= 1'b0;
      tick_q       <= '0;
      active_q     <= 1'b0;
      period_q     <= '0;
      raw_q        <= '0;
      scaled_q     <= '0;
      fresh_q      <= 1'b0;
      r10_q        <= '0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      dbc_q    <= dbc_d;
      clean_q  <= clean_d;
      tick_q   <= tick_d;
      active_q <= active_d;
      period_q <= period_d;
      raw_q    <= raw_d;
      scaled_q <= scaled_d;
      fresh_q  <= fresh_d;
      r10_q    <= r10_d;
      if (in_xfer) prev_clean_q <= t_clean;
    end
  end

  always_ff @(posedge clk_i) begin
    wk_q  <= wk_d;
    rem_q <= rem_d;
    div_q <= div_d;
    scl_q <= scl_d;
  end

  // --------------------------------------------------------------------------
  // Output register: hold the result until the receiver takes it
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (out_load)                   out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_level_q   <= clean_q;
      out_period_q  <= period_q;
      out_raw_q     <= raw_q;
      out_scaled_q  <= scaled_q;
      out_fresh_q   <= fresh_q;
      out_stopped_q <= !active_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign filtered_level_o  = out_level_q;
  assign period_ticks_o    = out_period_q;
  assign speed_raw_o       = out_raw_q;
  assign speed_scaled_o    = out_scaled_q;
  assign new_measurement_o = out_fresh_q;
  assign stopped_o         = out_stopped_q;

`ifndef SYNTHESIS
  // stopped counting always means cleared period and speeds
  a_stopped_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (period_q == '0 && raw_q == '0 && scaled_q == '0))
    else $error("speed state not cleared while stopped");

  // divide never runs with a zero period
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> div_q != '0)
    else $error("period divide with zero divisor");

  // divide-by-ten remainder stays below ten
  a_r10_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r10_q < TENTHS_W'(TENTHS_DIV))
    else $error("divide-by-ten remainder out of range");

  // an accepted tick always leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q != S_IDLE)
    else $error("tick accepted without processing");

  // serial step count stays inside the divide and multiply phases
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV |-> step_q < STEP_W'(DIV_STEPS)) and
    (state_q == S_MUL |-> step_q < STEP_W'(MUL_STEPS)))
    else $error("serial step count out of range");
`endif

endmodule

[sim/debounced_pulse_period_tachometer_tb.sv]
// ----------------------------------------------------------------------------
// debounced_pulse_period_tachometer_tb: self-checking tachometer regression
// Drives sensor ticks through the valid/ready input and predicts every result
// transfer with a cycle-free model of the debounce, period counter, timeout and
// speed arithmetic. A directed table runs first and covers register extremes,
// zero limit, zero timeout, arming edges and a timeout. Randomized pulse trains
// with bounce and noise follow, under many register settings. Both channels
// stall at random, and one long output hold-off backs up the input.
// ----------------------------------------------------------------------------
module debounced_pulse_period_tachometer_tb;
  import dppt_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned SETTLE       = 100;   // outlasts the serial edge path
  localparam int unsigned NUM_PHASES   = 12;
  localparam int unsigned PHASE_TICKS  = 105;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned IDLE_PCT     = 6;
  localparam int unsigned TENTHS       = 10;

  // One result transfer, field by field
  typedef struct packed {
    logic                filt;
    logic [PERIOD_W-1:0] period;
    logic [RAW_W-1:0]    raw;
    logic [SCALED_W-1:0] scaled;
    logic                fresh;
    logic                stopped;
  } tach_result_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

  // One row of the directed table: a tick (level in bit 0) or a register write
  typedef struct packed {
    row_kind_e            kind;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [PDATA_W-1:0]   value;
    logic                 typed;
    tach_result_t         want;
  } stim_row_t;

  localparam tach_result_t NONE = '0;
  localparam tach_result_t IDLE_LOW = '{filt: 1'b0, period: '0, raw: '0, scaled: '0,
                                        fresh: 1'b0, stopped: 1'b1};
  localparam tach_result_t ARMED = '{filt: 1'b1, period: '0, raw: '0, scaled: '0,
                                     fresh: 1'b1, stopped: 1'b0};
  localparam tach_result_t HIGH_STOPPED = '{filt: 1'b1, period: '0, raw: '0, scaled: '0,
                                            fresh: 1'b0, stopped: 1'b1};

  // Typed rows hold values that follow directly from the register settings;
  // all others are predicted.
  localparam int unsigned DIR_ROWS = 32;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    // after reset: low tick, then a high tick far below the default limit
    '{ROW_TICK,  '0,                 32'd0,        1'b1, IDLE_LOW},
    '{ROW_TICK,  '0,                 32'd1,        1'b1, IDLE_LOW},
    // extremes: full scale and numerator, zero limit, longest timeout
    '{ROW_WRITE, REG_SPEED_SCALE,    32'd65535,    1'b0, NONE},
    '{ROW_WRITE, REG_DEBOUNCE_LIMIT, 32'd0,        1'b0, NONE},
    '{ROW_WRITE, REG_TIMEOUT_TICKS,  32'd65535,    1'b0, NONE},
    '{ROW_WRITE, REG_RATE_NUMERATOR, 32'hFF_FFFF,  1'b0, NONE},
    // zero limit: one high tick raises the level; first edge only arms
    '{ROW_TICK,  '0,                 32'd1,        1'b1, ARMED},
    '{ROW_TICK,  '0,                 32'd0,        1'b0, NONE},
    '{ROW_TICK,  '0,                 32'd0,        1'b0, NONE},
    '{ROW_TICK,  '0,                 32'd1,        1'b0, NONE},   // period 3
    '{ROW_TICK,  '0,                 32'd0,        1'b0, NONE},
    '{ROW_TICK,  '0,                 32'd1,        1'b0, NONE},   // period 2, top speed
    // zero timeout: counting never survives a tick
    '{ROW_WRITE, REG_TIMEOUT_TICKS,  32'd0,        1'b0, NONE},
    '{ROW_TICK,  '0,                 32'd0,        1'b1, IDLE_LOW},
    '{ROW_TICK,  '0,                 32'd1,        1'b1, ARMED},
    '{ROW_TICK,  '0,                 32'd1,        1'b1, HIGH_STOPPED},
    // zero scale, short timeout: arm, measure, then run out
    '{ROW_WRITE, REG_SPEED_SCALE,    32'd0,        1'b0, NONE},
    '{ROW_WRITE, REG_DEBOUNCE_LIMIT, 32'd1,        1'b0, NONE},
    '{ROW_WRITE, REG_TIMEOUT_TICKS,  32'd5,        1'b0, NONE},
    '{ROW_WRITE, REG_RATE_NUMERATOR, 32'd1000,     1'b0, NONE},
    '{ROW_TICK,  '0,                 32'd0,        1'b1, IDLE_LOW},
    '{ROW_TICK,  '0,                 32'd1,        1'b1, IDLE_LOW},
    '{ROW_TICK,  '0,                 32'd1,        1'b1, ARMED},
    '{ROW_TICK,  '0,                 32'd0,        1'b0, NONE},
    '{ROW_TICK,  '0,                 32'd0,        1'b0, NONE},
    '{ROW_TICK,  '0,                 32'd1,        1'b0, NONE},
    '{ROW_TICK,  '0,                 32'd1,        1'b0, NONE},   // period 4
    '{ROW_TICK,  '0,                 32'd0,        1'b0, NONE},
    '{ROW_TICK,  '0,                 32'd0,        1'b0, NONE},
    '{ROW_TICK,  '0,                 32'd0,        1'b0, NONE},
    '{ROW_TICK,  '0,                 32'd0,        1'b0, NONE},
    '{ROW_TICK,  '0,                 32'd0,        1'b1, IDLE_LOW}  // timed out
  };

  // DUT ports
  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                sensor_level_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                filtered_level_o;
  logic [PERIOD_W-1:0] period_ticks_o;
  logic [RAW_W-1:0]    speed_raw_o;
  logic [SCALED_W-1:0] speed_scaled_o;
  logic                new_measurement_o;
  logic                stopped_o;

  // Register shadow used by the predictor
  logic [SCALE_W-1:0]   cfg_scale;
  logic [LIMIT_W-1:0]   cfg_limit;
  logic [TIMEOUT_W-1:0] cfg_timeout;
  logic [NUM_W-1:0]     cfg_numerator;

  // Predictor state
  logic [LIMIT_W-1:0]             integ_cnt;
  logic                           clean_q;
  logic                           clean_prev_q;
  logic [DEFAULT_PERIOD_BITS-1:0] tick_cnt;
  logic                           counting_q;
  logic [PERIOD_W-1:0]            period_q;
  logic [RAW_W-1:0]               raw_q;
  logic [SCALED_W-1:0]            scaled_q;

  tach_result_t   pending_results [$];
  int unsigned    mismatches;
  int unsigned    results_seen;
  int unsigned    ticks_sent;
  int unsigned    measured;
  int unsigned    timeouts_seen;
  int unsigned    settings_used;
  int unsigned    cycle_cnt;
  bit             quiet;      // no random idling on either side
  bit             hold_req;   // ask the receiver for one long hold-off

  debounced_pulse_period_tachometer DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .sensor_level_i    (sensor_level_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .filtered_level_o  (filtered_level_o),
    .period_ticks_o    (period_ticks_o),
    .speed_raw_o       (speed_raw_o),
    .speed_scaled_o    (speed_scaled_o),
    .new_measurement_o (new_measurement_o),
    .stopped_o         (stopped_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_tach_state();
    cfg_scale     = SCALE_RST;
    cfg_limit     = LIMIT_RST;
    cfg_timeout   = TIMEOUT_RST;
    cfg_numerator = NUMERATOR_RST;
    integ_cnt     = '0;
    clean_q       = 1'b0;
    clean_prev_q  = 1'b0;
    tick_cnt      = '0;
    counting_q    = 1'b0;
    period_q      = '0;
    raw_q         = '0;
    scaled_q      = '0;
  endfunction

  function automatic void store_reg(input logic [REG_IDX_W-1:0] idx,
                                    input logic [PDATA_W-1:0] value);
    case (idx)
      REG_SPEED_SCALE:    cfg_scale     = value[SCALE_W-1:0];
      REG_DEBOUNCE_LIMIT: cfg_limit     = value[LIMIT_W-1:0];
      REG_TIMEOUT_TICKS:  cfg_timeout   = value[TIMEOUT_W-1:0];
      REG_RATE_NUMERATOR: cfg_numerator = value[NUM_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [PDATA_W-1:0] reg_value(input logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_SPEED_SCALE:    return PDATA_W'(cfg_scale);
      REG_DEBOUNCE_LIMIT: return PDATA_W'(cfg_limit);
      REG_TIMEOUT_TICKS:  return PDATA_W'(cfg_timeout);
      default:            return PDATA_W'(cfg_numerator);
    endcase
  endfunction

  // Advance the tachometer by one tick and return the result it reports
  function automatic tach_result_t advance_tick(input logic level);
    tach_result_t res;
    logic [63:0]  prod;
    // integrate toward the raw level; flip the clean level at either end
    if (!level) begin
      if (integ_cnt == 0) clean_q = 1'b0;
      else integ_cnt = integ_cnt - 1'b1;
    end else begin
      if (integ_cnt >= cfg_limit) clean_q = 1'b1;
      else integ_cnt = integ_cnt + 1'b1;
    end
    // count first, saturating, then test the timeout
    if (counting_q && tick_cnt != '1) tick_cnt = tick_cnt + 1'b1;
    if (tick_cnt >= cfg_timeout) begin
      if (counting_q) timeouts_seen++;
      counting_q = 1'b0;
      tick_cnt   = '0;
      period_q   = '0;
      raw_q      = '0;
      scaled_q   = '0;
    end
    res.fresh = 1'b0;
    if (clean_q && !clean_prev_q) begin
      // a zero count only arms the counter
      counting_q = 1'b1;
      if (tick_cnt == 0) begin
        raw_q = '0;
      end else begin
        raw_q = RAW_W'(64'(cfg_numerator) / 64'(tick_cnt));
        measured++;
      end
      prod      = 64'(cfg_scale) * 64'(raw_q);
      scaled_q  = SCALED_W'(prod / TENTHS);
      period_q  = PERIOD_W'(tick_cnt);
      tick_cnt  = '0;
      res.fresh = 1'b1;
    end
    clean_prev_q = clean_q;
    res.filt    = clean_q;
    res.period  = period_q;
    res.raw     = raw_q;
    res.scaled  = scaled_q;
    res.stopped = !counting_q;
    return res;
  endfunction

  function automatic string show(input tach_result_t r);
    return $sformatf("level=%0b period=%0d raw=%0d scaled=%0d new=%0b stopped=%0b",
                     r.filt, r.period, r.raw, r.scaled, r.fresh, r.stopped);
  endfunction

  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus tasks; each one starts and ends at a falling edge
  // ---------------------------------------------------------------------------

  // Offer one tick, hold it until the transfer, then record its result
  task automatic send_tick(input logic level, input logic typed, input tach_result_t want);
    tach_result_t predicted;
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sensor_level_i <= level;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predicted = advance_tick(level);
    pending_results.push_back(typed ? want : predicted);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_run(input logic level, input int unsigned len);
    for (int unsigned k = 0; k < len; k++) send_tick(level, 1'b0, NONE);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Write a register, then read it back
  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    store_reg(idx, data);
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== reg_value(idx))
      note_failure($sformatf("register %0d read back 0x%0h, expected 0x%0h",
                             idx, prdata, reg_value(idx)));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_all(input logic [SCALE_W-1:0] scale, input logic [LIMIT_W-1:0] lim,
                           input logic [TIMEOUT_W-1:0] tmo, input logic [NUM_W-1:0] num);
    apb_write(REG_SPEED_SCALE,    PDATA_W'(scale));
    apb_write(REG_DEBOUNCE_LIMIT, PDATA_W'(lim));
    apb_write(REG_TIMEOUT_TICKS,  PDATA_W'(tmo));
    apb_write(REG_RATE_NUMERATOR, PDATA_W'(num));
    settings_used++;
  endtask

  // Mostly clean pulse trains sized to the debounce limit, plus bouncy
  // pulses, random noise, and stalls that outlast the timeout
  task automatic run_phase(input int unsigned budget);
    int unsigned start;
    int unsigned lim;
    int unsigned spread;
    int unsigned hi_len;
    int unsigned lo_len;
    int unsigned pick;
    start  = ticks_sent;
    lim    = cfg_limit;
    spread = (lim < 8 ? lim : 8) + 6;
    while (ticks_sent - start < budget) begin
      pick   = $urandom_range(0, 99);
      hi_len = lim + 1 + $urandom_range(0, spread);
      lo_len = lim + 1 + $urandom_range(0, spread);
      if (pick < 75) begin
        send_run(1'b1, hi_len);
        send_run(1'b0, lo_len);
      end else if (pick < 88) begin
        // short glitches inside each level exercise the debounce integrator
        send_run(1'b1, hi_len / 2 + 1);
        send_run(1'b0, $urandom_range(1, lim / 2 + 1));
        send_run(1'b1, hi_len);
        send_run(1'b0, lo_len / 2 + 1);
        send_run(1'b1, $urandom_range(1, lim / 2 + 1));
        send_run(1'b0, lo_len);
      end else if (pick < 96 || cfg_timeout > 400) begin
        repeat ($urandom_range(1, 24)) send_tick(1'($urandom_range(0, 1)), 1'b0, NONE);
      end else begin
        send_run(1'b0, cfg_timeout + lim + 2);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic [LIMIT_W-1:0]   lim;
    logic [TIMEOUT_W-1:0] tmo;
    logic [SCALE_W-1:0]   scale;
    logic [NUM_W-1:0]     num;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    sensor_level_i = 1'b0;
    quiet          = 1'b0;
    hold_req       = 1'b0;
    mismatches     = 0;
    results_seen   = 0;
    ticks_sent     = 0;
    measured       = 0;
    timeouts_seen  = 0;
    settings_used  = 0;
    reset_tach_state();

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table; register writes wait for an idle block
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_WRITE) begin
        drain();
        apb_write(DIRECTED[r].reg_idx, DIRECTED[r].value);
      end else begin
        send_tick(DIRECTED[r].value[0], DIRECTED[r].typed, DIRECTED[r].want);
      end
    end

    // Random phases, each under a fresh register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      if (p == 0) begin
        lim   = LIMIT_RST;
        tmo   = TIMEOUT_RST;
        scale = SCALE_RST;
        num   = NUMERATOR_RST;
      end else begin
        lim   = (p == 3) ? 8'd0 : (p == 7) ? 8'd255 : LIMIT_W'($urandom_range(1, 6));
        tmo   = (p == 5) ? 16'd0 : (p == 9) ? 16'hFFFF : (p == 10) ? 16'd1 :
                TIMEOUT_W'($urandom_range(2, 6 * lim + 40));
        scale = (p == 2) ? 16'hFFFF : (p == 4) ? 16'd0 : SCALE_W'($urandom_range(0, 16'hFFFF));
        num   = (p == 2) ? 24'hFF_FFFF : (p == 6) ? 24'd1 : NUM_W'($urandom());
      end
      write_all(scale, lim, tmo, num);
      // back up the output for a long stretch while ticks keep coming
      if (p == 1) hold_req = 1'b1;
      quiet = (p == 8);
      run_phase(PHASE_TICKS);
    end

    drain();
    repeat (SETTLE) @(negedge clk_i);
    if (pending_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_results.size()));

    $display("Ran %0d sensor ticks under %0d register settings: %0d speed measurements, %0d timeouts.",
             ticks_sent, settings_used, measured, timeouts_seen);
    $display("Checked %0d result transfers; %0d failures.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("debounced_pulse_period_tachometer regression: pass");
    end else begin
      $display("debounced_pulse_period_tachometer regression: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random backpressure, a quiet stretch, and one long hold-off
  // ---------------------------------------------------------------------------

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Compare every result transfer with the oldest pending prediction
  always @(posedge clk_i) begin : result_check
    tach_result_t got;
    tach_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      results_seen++;
      got = '{filt: filtered_level_o, period: period_ticks_o, raw: speed_raw_o,
              scaled: speed_scaled_o, fresh: new_measurement_o, stopped: stopped_o};
      if (pending_results.size() == 0) begin
        note_failure($sformatf("result with nothing pending: %s", show(got)));
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          note_failure($sformatf("result %0d\n  expected %s\n  actual   %s",
                                 results_seen, show(want), show(got)));
      end
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending.",
               cycle_cnt, pending_results.size());
      $display("debounced_pulse_period_tachometer regression: fail");
      $finish;
    end
  end

  initial cycle_cnt = 0;

endmodule

[files.f]
src/dppt_pkg.sv
src/debounced_pulse_period_tachometer.sv
sim/debounced_pulse_period_tachometer_tb.sv
